// ===== src/cms_pkg.sv =====
package cms_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int LABEL_WIDTH     = 16;
    localparam int TIME_WIDTH      = 16;
    localparam int CFG_WIDTH       = 8;
    localparam int MERGE_WIDTH     = 9;
    localparam int APB_DATA_WIDTH  = 32;
    localparam int APB_ADDR_WIDTH  = 3;

    localparam logic [TIME_WIDTH-1:0]  WARMUP_STEPS   = TIME_WIDTH'(20);
    localparam logic [LABEL_WIDTH-1:0] PEAK_MIN_LABEL = LABEL_WIDTH'(2);
    localparam logic [MERGE_WIDTH-1:0] MERGE_CNT_MAX  = '1;

    localparam int MERGE_GAP_MIN   = 1;
    localparam int MERGE_BUB_MIN   = 3;
    localparam int BUBBLE_GAP_MIN  = 2;
    localparam int BUBBLE_BUB_MIN  = 14;
    localparam int NURTURE_BUB_MAX = 5;

    typedef enum logic [1:0] {
        MODE_TYPICAL = 2'd0,
        MODE_BUBBLE  = 2'd1,
        MODE_MERGE   = 2'd2,
        MODE_NURTURE = 2'd3
    } t_mode;

    typedef enum logic {
        FUNC_SELECT = 1'b0,
        FUNC_REPORT = 1'b1
    } t_func;

    typedef enum logic {
        REG_DISCARD_COUNT     = 1'b0,
        REG_PARTITIONS_WANTED = 1'b1
    } t_reg;

endpackage

// ===== src/clustering_mode_sequencer.sv =====
// Channel   Handshake            Payload
// in        i_valid / o_ready    i_func, i_step_time, i_labels_after_bubbling,
//                                i_merge_stable, i_labels_changed
// out       o_valid / i_ready    o_chosen_mode, o_skip_work, o_finished,
//                                o_save_partition
// config    psel/penable/pwrite  paddr, pwdata, prdata, pready (always high)
//
// One item per cycle unless stalled: each item's result is computed in
// the accepting cycle and lands in the output register, visible on the
// next cycle. The output register is refilled in the cycle it is taken,
// so a stalled output only blocks input while its result waits.
// Synchronous active-low reset clears mode state, counters, config registers
// and output valid (partitions_wanted to 1, partition_changed to 1).
module clustering_mode_sequencer
    import cms_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_func,
    input  logic [TIME_WIDTH-1:0]     i_step_time,
    input  logic [LABEL_WIDTH-1:0]    i_labels_after_bubbling,
    input  logic                      i_merge_stable,
    input  logic                      i_labels_changed,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_chosen_mode,
    output logic                      o_skip_work,
    output logic                      o_finished,
    output logic                      o_save_partition,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    logic [CFG_WIDTH-1:0]   r_discard_count;
    logic [CFG_WIDTH-1:0]   r_partitions_wanted;
    t_mode                  r_mode,              n_mode;
    logic [COUNT_WIDTH-1:0] r_since_typical,     n_since_typical;
    logic [COUNT_WIDTH-1:0] r_since_bubble,      n_since_bubble;
    logic [COUNT_WIDTH-1:0] r_since_merge,       n_since_merge;
    logic                   r_merge_allowed,     n_merge_allowed;
    logic                   r_peak_seen,         n_peak_seen;
    logic                   r_after_peak,        n_after_peak;
    logic [LABEL_WIDTH-1:0] r_max_label,         n_max_label;
    logic [MERGE_WIDTH-1:0] r_stable_merges,     n_stable_merges;
    logic                   r_partition_changed, n_partition_changed;
    logic                   r_skip_pending,      n_skip_pending;
    logic                   n_save;
    logic                   r_out_valid;
    logic [1:0]             r_out_mode;
    logic                   r_out_skip;
    logic                   r_out_finished;
    logic                   r_out_save;

    logic                   in_accept;
    logic                   cfg_write;
    t_reg                   cfg_sel;
    t_mode                  sel_mode;
    logic [LABEL_WIDTH+3:0] max_x10;
    logic [LABEL_WIDTH+3:0] labels_x9;
    logic                   peak_hit;
    logic [MERGE_WIDTH:0]   finish_lhs;
    logic [MERGE_WIDTH:0]   finish_rhs;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        sat_inc = (&v) ? v : v + CNT_ONE;
    endfunction

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = t_reg'(paddr[2]);

    always_comb begin
        unique case (cfg_sel)
            REG_DISCARD_COUNT:     prdata = APB_DATA_WIDTH'(r_discard_count);
            REG_PARTITIONS_WANTED: prdata = APB_DATA_WIDTH'(r_partitions_wanted);
            default:               prdata = '0;
        endcase
    end

    assign o_ready   = !r_out_valid || i_ready;
    assign in_accept = i_valid && o_ready;

    always_comb begin
        sel_mode = MODE_TYPICAL;
        if (i_step_time >= WARMUP_STEPS) begin
            if (r_merge_allowed) begin
                if (r_since_merge > COUNT_WIDTH'(MERGE_GAP_MIN) &&
                    r_since_bubble > COUNT_WIDTH'(MERGE_BUB_MIN)) begin
                    sel_mode = MODE_MERGE;
                end
            end else if (r_since_merge > COUNT_WIDTH'(BUBBLE_GAP_MIN) &&
                         r_since_bubble > COUNT_WIDTH'(BUBBLE_BUB_MIN)) begin
                sel_mode = MODE_BUBBLE;
            end else if (r_since_merge > COUNT_WIDTH'(MERGE_GAP_MIN) &&
                         r_since_bubble < COUNT_WIDTH'(NURTURE_BUB_MAX)) begin
                sel_mode = MODE_NURTURE;
            end
        end
    end

    assign max_x10   = (LABEL_WIDTH+4)'(r_max_label) * (LABEL_WIDTH+4)'(10);
    assign labels_x9 = (LABEL_WIDTH+4)'(i_labels_after_bubbling) * (LABEL_WIDTH+4)'(9);
    assign peak_hit  = (i_labels_after_bubbling > PEAK_MIN_LABEL) && (max_x10 > labels_x9);

    always_comb begin
        n_mode              = r_mode;
        n_skip_pending      = r_skip_pending;
        n_since_typical     = r_since_typical;
        n_since_bubble      = r_since_bubble;
        n_since_merge       = r_since_merge;
        n_merge_allowed     = r_merge_allowed;
        n_peak_seen         = r_peak_seen;
        n_after_peak        = r_after_peak;
        n_max_label         = r_max_label;
        n_stable_merges     = r_stable_merges;
        n_partition_changed = r_partition_changed;
        n_save              = 1'b0;
        case (t_func'(i_func))
            FUNC_SELECT: begin
                n_mode         = sel_mode;
                n_skip_pending = (sel_mode == MODE_TYPICAL) && (r_since_typical == CNT_ONE) &&
                                 !r_partition_changed;
            end
            default: begin
                if (r_mode == MODE_TYPICAL && !r_skip_pending) begin
                    n_partition_changed = i_labels_changed;
                end
                n_since_typical = (r_mode == MODE_TYPICAL) ? CNT_ONE : sat_inc(r_since_typical);
                n_since_bubble  = (r_mode == MODE_BUBBLE)  ? CNT_ONE : sat_inc(r_since_bubble);
                n_since_merge   = (r_mode == MODE_MERGE)   ? CNT_ONE : sat_inc(r_since_merge);
                if (r_mode == MODE_BUBBLE) begin
                    if (!r_peak_seen) begin
                        n_peak_seen = peak_hit;
                        if (i_labels_after_bubbling > r_max_label) begin
                            n_max_label = i_labels_after_bubbling;
                        end
                    end
                    if (n_peak_seen) begin
                        if (r_after_peak) begin
                            n_after_peak    = 1'b0;
                            n_merge_allowed = 1'b1;
                        end else begin
                            n_after_peak = 1'b1;
                        end
                    end
                end else if (r_mode == MODE_MERGE) begin
                    n_peak_seen  = 1'b0;
                    n_after_peak = 1'b0;
                    n_max_label  = '0;
                    if (i_merge_stable) begin
                        n_merge_allowed = 1'b0;
                        if (r_stable_merges != MERGE_CNT_MAX) begin
                            n_stable_merges = r_stable_merges + MERGE_WIDTH'(1);
                        end
                        n_save = n_stable_merges >= MERGE_WIDTH'(r_discard_count);
                    end
                end
            end
        endcase
    end

    assign finish_lhs = (MERGE_WIDTH+1)'(n_stable_merges) + (MERGE_WIDTH+1)'(1);
    assign finish_rhs = (MERGE_WIDTH+1)'(r_partitions_wanted) +
                        (MERGE_WIDTH+1)'(r_discard_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discard_count     <= '0;
            r_partitions_wanted <= CFG_WIDTH'(1);
        end else if (cfg_write) begin
            unique case (cfg_sel)
                REG_DISCARD_COUNT:     r_discard_count     <= pwdata[CFG_WIDTH-1:0];
                REG_PARTITIONS_WANTED: r_partitions_wanted <= pwdata[CFG_WIDTH-1:0];
                default:               r_discard_count     <= r_discard_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode              <= MODE_TYPICAL;
            r_skip_pending      <= 1'b0;
            r_since_typical     <= '0;
            r_since_bubble      <= '0;
            r_since_merge       <= '0;
            r_merge_allowed     <= 1'b0;
            r_peak_seen         <= 1'b0;
            r_after_peak        <= 1'b0;
            r_max_label         <= '0;
            r_stable_merges     <= '0;
            r_partition_changed <= 1'b1;
        end else if (in_accept) begin
            r_mode              <= n_mode;
            r_skip_pending      <= n_skip_pending;
            r_since_typical     <= n_since_typical;
            r_since_bubble      <= n_since_bubble;
            r_since_merge       <= n_since_merge;
            r_merge_allowed     <= n_merge_allowed;
            r_peak_seen         <= n_peak_seen;
            r_after_peak        <= n_after_peak;
            r_max_label         <= n_max_label;
            r_stable_merges     <= n_stable_merges;
            r_partition_changed <= n_partition_changed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_mode     <= n_mode;
            r_out_skip     <= n_skip_pending;
            r_out_finished <= finish_lhs >= finish_rhs;
            r_out_save     <= n_save;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_chosen_mode    = r_out_mode;
    assign o_skip_work      = r_out_skip;
    assign o_finished       = r_out_finished;
    assign o_save_partition = r_out_save;

    a_save_only_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_save_partition |-> o_chosen_mode == MODE_MERGE)
        else $error("save flagged outside merge mode");

    a_skip_only_typical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_skip_work |-> o_chosen_mode == MODE_TYPICAL)
        else $error("skip flagged outside typical mode");

    a_merges_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_stable_merges >= $past(r_stable_merges))
        else $error("stable merge count decreased");

    a_merge_enable_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_merge_allowed) |->
            $past(in_accept && i_func && r_mode == MODE_BUBBLE))
        else $error("merge permission set outside bubble report");

endmodule
